// File: src/peak_to_rms_crest_factor_defines.svh
// Assertion macros used by the checker file.
`ifndef PEAK_TO_RMS_CREST_FACTOR_DEFINES_SVH
`define PEAK_TO_RMS_CREST_FACTOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PTRCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PTRCF_ASSERT_IMP(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// File: src/ptrcf_pkg.sv
package ptrcf_pkg;

    localparam int DEF_MAX_LEN     = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int IN_W      = 16;
    localparam int RATIO_W   = 23;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 13;
    localparam int FRAC_BITS = 32;
    localparam int Q_DEPTH   = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

    typedef struct packed {
        logic signed [IN_W-1:0] sample_re;
        logic signed [IN_W-1:0] sample_im;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic [RATIO_W-1:0]  ratio;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  sample_count;
    } t_out_item;

endpackage

// File: src/peak_to_rms_crest_factor.sv
// Channel  | Signals                                | Direction | Transfer when
// ---------+----------------------------------------+-----------+--------------------------
// input    | i_in_valid, o_in_stall, i_in_item      | in        | i_in_valid && !o_in_stall
// output   | o_out_valid, i_out_stall, o_out_item   | out       | o_out_valid && !i_out_stall
// config   | i_cfg_wr_en, i_cfg_wr_data             | in        | i_cfg_wr_en
//
// Samples transfer one per cycle unless the input stalls; the front squares and
// accumulates them with no gaps. A last sample hands peak, sum and count to a
// two-entry queue; the back takes one queued vector at a time through a
// one-bit-per-cycle multiply, divide and root.
// The input stalls only when a last sample finds the queue full.
// Reset (i_rst_n low at a clock edge) clears accumulators, queue, state and mode.
module peak_to_rms_crest_factor #(
    parameter int MAX_LEN     = ptrcf_pkg::DEF_MAX_LEN,
    parameter int SAMPLE_BITS = ptrcf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ptrcf_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ptrcf_pkg::t_out_item  o_out_item
);
    localparam int MAG_W = 2 * SAMPLE_BITS;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = MAG_W + CNT_W;
    localparam int JOB_W = MAG_W + SUM_W + CNT_W + 1;

    // Mode register: complex samples add the imaginary square.
    logic r_complex;

    // Front to queue: one finished vector per transfer.
    logic             push, q_full, pop, q_empty;
    logic [MAG_W-1:0] f_peak;
    logic [SUM_W-1:0] f_sum;
    logic [CNT_W-1:0] f_count;
    logic             f_exc;
    logic [JOB_W-1:0] q_in, q_out;

    // Queue to back: the vector the back is about to evaluate.
    logic [MAG_W-1:0] b_peak;
    logic [SUM_W-1:0] b_sum;
    logic [CNT_W-1:0] b_count;
    logic             b_exc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complex <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_complex <= i_cfg_wr_data;
        end
    end

    ptrcf_front #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_complex  (r_complex),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_peak     (f_peak),
        .o_sum      (f_sum),
        .o_count    (f_count),
        .o_exceeded (f_exc)
    );

    // Pack the vector summary so the queue stays width-agnostic.
    assign q_in = {f_peak, f_sum, f_count, f_exc};

    ptrcf_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign {b_peak, b_sum, b_count, b_exc} = q_out;

    ptrcf_back #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .i_peak      (b_peak),
        .i_sum       (b_sum),
        .i_count     (b_count),
        .i_exceeded  (b_exc),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: src/ptrcf_front.sv
module ptrcf_front #(
    parameter int MAX_LEN     = ptrcf_pkg::DEF_MAX_LEN,
    parameter int SAMPLE_BITS = ptrcf_pkg::DEF_SAMPLE_BITS,
    localparam int MAG_W = 2 * SAMPLE_BITS,
    localparam int CNT_W = $clog2(MAX_LEN + 1),
    localparam int SUM_W = MAG_W + CNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_complex,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ptrcf_pkg::t_in_item   i_in_item,
    input  logic                  i_q_full,
    output logic                  o_push,
    output logic [MAG_W-1:0]      o_peak,
    output logic [SUM_W-1:0]      o_sum,
    output logic [CNT_W-1:0]      o_count,
    output logic                  o_exceeded
);
    localparam int EXT_W = SAMPLE_BITS + ptrcf_pkg::IN_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic [MAG_W-1:0]       r_s1_re_sq;
    logic [MAG_W-1:0]       r_s1_im_sq;
    logic [MAG_W-1:0]       r_peak,  n_peak;
    logic [SUM_W-1:0]       r_sum,   n_sum;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_exc,   n_exc;

    logic [EXT_W-1:0]       re_ext, im_ext;
    logic [SAMPLE_BITS-1:0] re_s, im_s, re_mag, im_mag;
    logic [MAG_W-1:0]       mag_sq;
    logic                   s1_go;
    logic                   in_take;

    // Read only the low SAMPLE_BITS bits of each field as two's complement.
    assign re_ext = {{SAMPLE_BITS{1'b0}}, i_in_item.sample_re};
    assign im_ext = {{SAMPLE_BITS{1'b0}}, i_in_item.sample_im};
    assign re_s   = re_ext[SAMPLE_BITS-1:0];
    assign im_s   = im_ext[SAMPLE_BITS-1:0];
    assign re_mag = re_s[SAMPLE_BITS-1] ? (~re_s + 1'b1) : re_s;
    assign im_mag = im_s[SAMPLE_BITS-1] ? (~im_s + 1'b1) : im_s;

    // A last sample waits in stage one until the queue has room.
    assign s1_go      = r_s1_valid && (!r_s1_last || !i_q_full);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    assign mag_sq = r_s1_re_sq + (i_complex ? r_s1_im_sq : {MAG_W{1'b0}});

    always_comb begin
        n_peak  = r_peak;
        n_sum   = r_sum;
        n_count = r_count;
        n_exc   = r_exc;
        if (r_count >= MAX_CNT) begin
            n_exc = 1'b1;
        end else begin
            if (mag_sq > r_peak) begin
                n_peak = mag_sq;
            end
            n_sum   = r_sum + SUM_W'(mag_sq);
            n_count = r_count + 1'b1;
        end
    end

    assign o_push     = s1_go && r_s1_last;
    assign o_peak     = n_peak;
    assign o_sum      = n_sum;
    assign o_count    = n_count;
    assign o_exceeded = n_exc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_peak     <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_exc      <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                if (r_s1_last) begin
                    r_peak  <= '0;
                    r_sum   <= '0;
                    r_count <= '0;
                    r_exc   <= 1'b0;
                end else begin
                    r_peak  <= n_peak;
                    r_sum   <= n_sum;
                    r_count <= n_count;
                    r_exc   <= n_exc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_last  <= i_in_item.last;
            r_s1_re_sq <= re_mag * re_mag;
            r_s1_im_sq <= im_mag * im_mag;
        end
    end

endmodule

// File: src/ptrcf_queue.sv
module ptrcf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = $clog2(ptrcf_pkg::Q_DEPTH);
    localparam int CW    = $clog2(ptrcf_pkg::Q_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ptrcf_pkg::Q_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [WIDTH-1:0] r_mem [ptrcf_pkg::Q_DEPTH];
    logic [WIDTH-1:0] r_head;
    logic [PTR_W-1:0] r_wr, r_rd, rd_next;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop, head_load;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_head;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign rd_next = r_rd + 1'b1;

    // Load the head straight from the input when the pushed entry is next out.
    assign head_load = do_push && ((r_cnt == '0) || (do_pop && (r_cnt == ONE_C)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (head_load) begin
            r_head <= i_data;
        end else if (do_pop) begin
            r_head <= r_mem[rd_next];
        end
    end

endmodule

// File: src/ptrcf_back.sv
module ptrcf_back #(
    parameter int MAX_LEN     = ptrcf_pkg::DEF_MAX_LEN,
    parameter int SAMPLE_BITS = ptrcf_pkg::DEF_SAMPLE_BITS,
    localparam int MAG_W = 2 * SAMPLE_BITS,
    localparam int CNT_W = $clog2(MAX_LEN + 1),
    localparam int SUM_W = MAG_W + CNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    input  logic [MAG_W-1:0]      i_peak,
    input  logic [SUM_W-1:0]      i_sum,
    input  logic [CNT_W-1:0]      i_count,
    input  logic                  i_exceeded,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ptrcf_pkg::t_out_item  o_out_item
);
    localparam int NUM_W  = MAG_W + CNT_W;
    localparam int Q_W    = CNT_W + ptrcf_pkg::FRAC_BITS;
    localparam int RT_W   = (Q_W + 1) / 2;
    localparam int SQ_IN  = 2 * RT_W;
    localparam int STEP_W = $clog2(Q_W + 1);
    localparam int SAT_W  = RT_W + ptrcf_pkg::RATIO_W;
    localparam int CX_W   = CNT_W + ptrcf_pkg::COUNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_mcand, r_num, n_num;
    logic [CNT_W-1:0]  r_mplier, r_count;
    logic [SUM_W-1:0]  r_den, r_rem, n_rem;
    logic [Q_W-1:0]    r_dsr, n_dsr;
    logic [SQ_IN-1:0]  r_op;
    logic [RT_W-1:0]   r_root, r_srem, n_srem;
    logic              r_exc, r_zero;
    logic              r_out_valid;
    ptrcf_pkg::t_out_item r_out_item, n_out_item;

    logic [SUM_W:0]    d_t, d_diff;
    logic              d_ge;
    logic [RT_W+1:0]   s_t, s_trial, s_diff;
    logic              s_ge;
    logic [SAT_W-1:0]  root_ext;
    logic [CX_W-1:0]   count_ext;
    logic              out_free;

    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Shift-add multiply: one bit of the count per cycle.
    assign n_num = r_mplier[0] ? (r_num + r_mcand) : r_num;

    // Restoring divide: one quotient bit per cycle.
    assign d_t    = {r_rem, r_dsr[Q_W-1]};
    assign d_ge   = d_t >= {1'b0, r_den};
    assign d_diff = d_t - {1'b0, r_den};
    assign n_rem  = d_ge ? d_diff[SUM_W-1:0] : d_t[SUM_W-1:0];
    assign n_dsr  = {r_dsr[Q_W-2:0], d_ge};

    // Digit-by-digit square root: one root bit per cycle.
    assign s_t     = {r_srem, r_op[SQ_IN-1 -: 2]};
    assign s_trial = {r_root, 2'b01};
    assign s_ge    = s_t >= s_trial;
    assign s_diff  = s_t - s_trial;
    assign n_srem  = s_ge ? s_diff[RT_W-1:0] : s_t[RT_W-1:0];

    assign root_ext  = SAT_W'(r_root);
    assign count_ext = CX_W'(r_count);

    always_comb begin
        n_out_item.ratio = (root_ext > SAT_W'(ptrcf_pkg::RATIO_MAX))
                           ? ptrcf_pkg::RATIO_MAX : root_ext[ptrcf_pkg::RATIO_W-1:0];
        if (r_exc) begin
            n_out_item.status = ptrcf_pkg::STATUS_LONG;
        end else if (r_zero) begin
            n_out_item.status = ptrcf_pkg::STATUS_ZERO;
        end else begin
            n_out_item.status = ptrcf_pkg::STATUS_OK;
        end
        n_out_item.sample_count = count_ext[ptrcf_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A new result from DONE takes the place of the one leaving.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= (i_sum == '0) ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == '0) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mcand  <= NUM_W'(i_peak);
                r_mplier <= i_count;
                r_count  <= i_count;
                r_num    <= '0;
                r_den    <= i_sum;
                r_exc    <= i_exceeded;
                r_zero   <= (i_sum == '0);
                r_root   <= '0;
                r_srem   <= '0;
                r_step   <= STEP_W'(CNT_W - 1);
            end
            S_MUL: begin
                r_num    <= n_num;
                r_mcand  <= {r_mcand[NUM_W-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                r_step   <= r_step - 1'b1;
                if (r_step == '0) begin
                    // Quotient fits Q_W bits, so the top part starts below the divisor.
                    r_rem  <= SUM_W'(n_num[NUM_W-1:CNT_W]);
                    r_dsr  <= {n_num[CNT_W-1:0], {ptrcf_pkg::FRAC_BITS{1'b0}}};
                    r_step <= STEP_W'(Q_W - 1);
                end
            end
            S_DIV: begin
                r_rem  <= n_rem;
                r_dsr  <= n_dsr;
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_op   <= SQ_IN'(n_dsr);
                    r_step <= STEP_W'(RT_W - 1);
                end
            end
            S_SQRT: begin
                r_srem <= n_srem;
                r_root <= {r_root[RT_W-2:0], s_ge};
                r_op   <= {r_op[SQ_IN-3:0], 2'b00};
                r_step <= r_step - 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_item <= n_out_item;
                end
            end
            default: begin
                r_step <= '0;
            end
        endcase
    end

endmodule

// File: src/ptrcf_checker.sv
`include "peak_to_rms_crest_factor_defines.svh"

module ptrcf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic                  i_cfg_wr_data,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input ptrcf_pkg::t_in_item   i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input ptrcf_pkg::t_out_item  o_out_item
);
    localparam logic [ptrcf_pkg::RATIO_W-1:0] RATIO_ONE =
        ptrcf_pkg::RATIO_W'(1 << 16);

    // Hold a stalled result until it transfers.
    `PTRCF_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `PTRCF_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_out_item), "stalled result changed")
    // An all-zero vector has no ratio.
    `PTRCF_ASSERT_IMP(a_zero_ratio, o_out_valid && o_out_item.status == ptrcf_pkg::STATUS_ZERO, o_out_item.ratio == '0, "zero vector with nonzero ratio")
    // Peak over rms is never below one.
    `PTRCF_ASSERT_IMP(a_ok_ratio, o_out_valid && o_out_item.status == ptrcf_pkg::STATUS_OK, o_out_item.ratio >= RATIO_ONE, "crest factor below one")

endmodule

bind peak_to_rms_crest_factor ptrcf_checker u_checker (.*);
